### design/two_link_inverse_kinematics_unit_macros.svh
// Assertion macros for the checker file of the inverse kinematics unit.
// No dependencies; take in by `include with the bare file name.
`ifndef TWO_LINK_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`define TWO_LINK_INVERSE_KINEMATICS_UNIT_MACROS_SVH

// Checked at every clock edge outside reset
`define IKL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// Checked at every clock edge, reset included
`define IKL_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error(msg);

`endif

### design/ikl_pkg.sv
// Package for the two-link inverse kinematics unit: widths, beat types,
// register indexes, arctangent table and angle rounding. No dependencies.
`default_nettype none

package ikl_pkg;

  // Field widths
  localparam int COORD_BITS = 20;
  localparam int ANGLE_BITS = 16;
  localparam int LEN_BITS   = 18;
  localparam int CFG_IDX_BITS = 8;

  // Derived datapath widths
  localparam int DW  = 2 * COORD_BITS + 1;   // x^2 + y^2
  localparam int SQW = 2 * LEN_BITS;         // l1^2, l2^2, (l1-l2)^2
  localparam int SW  = 2 * (LEN_BITS + 1);   // (l1+l2)^2, sqrt operands, root
  localparam int QW  = DW + 1;               // signed cosine-law terms
  localparam int PW  = 2 * SW;               // sqrt radicand
  localparam int AW  = 64;                   // CORDIC vector width
  localparam int ZW  = 32;                   // angle accumulator, one turn = 2^ZW

  // CORDIC set-up
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_STAGES  = 6;
  localparam int NORM_MSB     = 59;
  localparam logic [ZW-1:0] HALF_TURN = ZW'(1) << (ZW - 1);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER = CFG_IDX_BITS'(1);
  localparam logic [LEN_BITS-1:0]     LEN_RESET = LEN_BITS'(4096);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
  } target_t;

  typedef struct packed {
    logic                  reachable;
    logic [ANGLE_BITS-1:0] shoulder_a;
    logic [ANGLE_BITS-1:0] elbow_a;
    logic [ANGLE_BITS-1:0] shoulder_b;
    logic [ANGLE_BITS-1:0] elbow_b;
  } result_t;

  // Values that ride alongside the square root pipeline
  typedef struct packed {
    logic                         reach;
    logic signed [QW-1:0]         qa;
    logic signed [QW-1:0]         nb;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } side_t;

  // atan(2^-i) in turns, Q32
  function automatic logic [ZW-1:0] atan_step(input int unsigned i);
    case (i)
      0:  return ZW'(536870912);
      1:  return ZW'(316933406);
      2:  return ZW'(167458907);
      3:  return ZW'(85004756);
      4:  return ZW'(42667331);
      5:  return ZW'(21354465);
      6:  return ZW'(10680862);
      7:  return ZW'(5340245);
      8:  return ZW'(2670163);
      9:  return ZW'(1335087);
      10: return ZW'(667544);
      11: return ZW'(333772);
      12: return ZW'(166886);
      13: return ZW'(83443);
      14: return ZW'(41722);
      15: return ZW'(20861);
      16: return ZW'(10430);
      17: return ZW'(5215);
      18: return ZW'(2608);
      19: return ZW'(1304);
      20: return ZW'(652);
      21: return ZW'(326);
      22: return ZW'(163);
      23: return ZW'(81);
      24: return ZW'(41);
      25: return ZW'(20);
      26: return ZW'(10);
      27: return ZW'(5);
      28: return ZW'(3);
      29: return ZW'(1);
      default: return '0;
    endcase
  endfunction

  // Round half up from a Q32 turn to ANGLE_BITS, wrapping
  function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [ZW-1:0] a);
    logic [ZW-1:0] r;
    r = a + (ZW'(1) << (ZW - 1 - ANGLE_BITS));
    return r[ZW-1 -: ANGLE_BITS];
  endfunction

endpackage

`default_nettype wire

### design/ikl_front.sv
// Front end: squares, reach test and cosine-law terms, four register stages.
// Depends on ikl_pkg.
`default_nettype none

module ikl_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_vld,
  input  wire ikl_pkg::target_t                target,
  input  wire logic [ikl_pkg::LEN_BITS-1:0]    l1,
  input  wire logic [ikl_pkg::LEN_BITS-1:0]    l2,
  output logic                                 out_vld,
  output logic [ikl_pkg::SW-1:0]               a_opnd,
  output logic [ikl_pkg::SW-1:0]               b_opnd,
  output ikl_pkg::side_t                       side
);

  localparam int CW  = ikl_pkg::COORD_BITS;
  localparam int LW  = ikl_pkg::LEN_BITS;
  localparam int DW  = ikl_pkg::DW;
  localparam int SQW = ikl_pkg::SQW;
  localparam int SW  = ikl_pkg::SW;
  localparam int QW  = ikl_pkg::QW;

  // Stage 1: magnitudes, link sum and difference
  logic                 v1;
  logic signed [CW-1:0] x1, y1;
  logic [CW-1:0]        ax1, ay1;
  logic [LW-1:0]        l1_1, l2_1, ldif1;
  logic [LW:0]          lsum1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= target.target_x;
      y1    <= target.target_y;
      ax1   <= target.target_x[CW-1] ? CW'(-target.target_x) : CW'(target.target_x);
      ay1   <= target.target_y[CW-1] ? CW'(-target.target_y) : CW'(target.target_y);
      l1_1  <= l1;
      l2_1  <= l2;
      lsum1 <= (LW+1)'(l1) + (LW+1)'(l2);
      ldif1 <= (l1 > l2) ? l1 - l2 : l2 - l1;
    end
  end

  // Stage 2: squares
  logic                 v2;
  logic signed [CW-1:0] x2, y2;
  logic [2*CW-1:0]      axsq2, aysq2;
  logic [SQW-1:0]       l1sq2, l2sq2, difsq2;
  logic [SW-1:0]        sumsq2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2     <= x1;
      y2     <= y1;
      axsq2  <= (2*CW)'(ax1) * (2*CW)'(ax1);
      aysq2  <= (2*CW)'(ay1) * (2*CW)'(ay1);
      l1sq2  <= SQW'(l1_1) * SQW'(l1_1);
      l2sq2  <= SQW'(l2_1) * SQW'(l2_1);
      difsq2 <= SQW'(ldif1) * SQW'(ldif1);
      sumsq2 <= SW'(lsum1) * SW'(lsum1);
    end
  end

  // Stage 3: squared distance and link-only sums
  logic                  v3;
  logic signed [CW-1:0]  x3, y3;
  logic [DW-1:0]         d2_3;
  logic signed [SQW:0]   ldelta3;
  logic [SQW:0]          lss3;
  logic [SQW-1:0]        difsq3;
  logic [SW-1:0]         sumsq3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3      <= x2;
      y3      <= y2;
      d2_3    <= DW'(axsq2) + DW'(aysq2);
      ldelta3 <= $signed({1'b0, l1sq2}) - $signed({1'b0, l2sq2});
      lss3    <= (SQW+1)'(l1sq2) + (SQW+1)'(l2sq2);
      difsq3  <= difsq2;
      sumsq3  <= sumsq2;
    end
  end

  // Stage 4: reach test, sqrt operands, cosine-law numerators
  logic reach3;
  assign reach3 = (d2_3 != '0) && (d2_3 <= DW'(sumsq3)) && (d2_3 >= DW'(difsq3));

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_opnd     <= SW'(d2_3 - DW'(difsq3));
      b_opnd     <= SW'(DW'(sumsq3) - d2_3);
      side.reach <= reach3;
      side.qa    <= $signed({1'b0, d2_3}) + QW'(ldelta3);
      side.nb    <= QW'($signed({1'b0, lss3})) - $signed({1'b0, d2_3});
      side.x     <= x3;
      side.y     <= y3;
    end
  end

endmodule

`default_nettype wire

### design/ikl_sqrt.sv
// Pipelined floor(sqrt(a*b)): split multiply over two stages, then one root
// bit per stage. Depends on ikl_pkg.
`default_nettype none

module ikl_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_vld,
  input  wire logic [ikl_pkg::SW-1:0]   a_opnd,
  input  wire logic [ikl_pkg::SW-1:0]   b_opnd,
  input  wire ikl_pkg::side_t           side_in,
  output logic                          out_vld,
  output logic [ikl_pkg::SW-1:0]        root,
  output ikl_pkg::side_t                side_out
);

  localparam int SW  = ikl_pkg::SW;
  localparam int PW  = ikl_pkg::PW;
  localparam int PW1 = PW + 1;
  localparam int HB  = SW / 2;
  localparam int MW  = SW + SW - HB;

  // Multiply stage: two partial products
  logic                 m_vld;
  logic [MW-1:0]        pp_lo, pp_hi;
  ikl_pkg::side_t       m_side;

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else if (en) m_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo  <= MW'(a_opnd) * MW'(b_opnd[HB-1:0]);
      pp_hi  <= MW'(a_opnd) * MW'(b_opnd[SW-1:HB]);
      m_side <= side_in;
    end
  end

  // Root stages; index 0 is the summed radicand
  logic                 vld_q  [0:SW];
  logic [PW-1:0]        rem_q  [0:SW];
  logic [SW-1:0]        root_q [0:SW];
  ikl_pkg::side_t       side_q [0:SW];

  always_ff @(posedge clk) begin
    if (rst) vld_q[0] <= 1'b0;
    else if (en) vld_q[0] <= m_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= PW'(pp_lo) + (PW'(pp_hi) << HB);
      root_q[0] <= '0;
      side_q[0] <= m_side;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_bit
    localparam int B = SW - 1 - k;
    logic [PW1-1:0] trial;
    logic           take;

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (PW1'(root_q[k]) << (B + 1)) | (PW1'(1) << (2 * B));
    assign take  = {1'b0, rem_q[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) vld_q[k+1] <= 1'b0;
      else if (en) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= take ? rem_q[k] - trial[PW-1:0] : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (SW'(1) << B)) : root_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_vld  = vld_q[SW];
  assign root     = root_q[SW];
  assign side_out = side_q[SW];

endmodule

`default_nettype wire

### design/ikl_atan2.sv
// Pipelined atan2 in Q32 turns: half-plane fold, six normalising shift
// stages, thirty vectoring CORDIC stages. Depends on ikl_pkg.
`default_nettype none

module ikl_atan2 (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_vld,
  input  wire logic                            in_tag,
  input  wire logic signed [ikl_pkg::AW-1:0]   x_in,
  input  wire logic signed [ikl_pkg::AW-1:0]   y_in,
  output logic                                 out_vld,
  output logic                                 out_tag,
  output logic [ikl_pkg::ZW-1:0]               angle
);

  localparam int AW   = ikl_pkg::AW;
  localparam int ZW   = ikl_pkg::ZW;
  localparam int NS   = ikl_pkg::NORM_STAGES;
  localparam int CS   = ikl_pkg::CORDIC_STEPS;
  localparam int LAST = NS + CS;

  logic signed [AW-1:0] sx    [0:LAST];
  logic signed [AW-1:0] sy    [0:LAST];
  logic [ZW-1:0]        sz    [0:LAST];
  logic                 sbase [0:LAST];
  logic                 szero [0:LAST];
  logic                 svld  [0:LAST];
  logic                 stag  [0:LAST];
  logic [AW-1:0]        nm    [0:NS];

  // Fold into the right half-plane
  logic                 neg;
  logic signed [AW-1:0] xf, yf, yabs, mx;

  assign neg  = x_in[AW-1];
  assign xf   = neg ? -x_in : x_in;
  assign yf   = neg ? -y_in : y_in;
  assign yabs = yf[AW-1] ? -yf : yf;
  assign mx   = (xf > yabs) ? xf : yabs;

  always_ff @(posedge clk) begin
    if (rst) svld[0] <= 1'b0;
    else if (en) svld[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]    <= xf;
      sy[0]    <= yf;
      sz[0]    <= neg ? ikl_pkg::HALF_TURN : '0;
      sbase[0] <= neg;
      szero[0] <= (mx == '0);
      stag[0]  <= in_tag;
      nm[0]    <= mx;
    end
  end

  // Normalise: larger magnitude into [2^59, 2^60)
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - j);
    localparam logic [AW-1:0] LIM = AW'(1) << (ikl_pkg::NORM_MSB + 1 - SH);
    logic small_m;

    assign small_m = nm[j] < LIM;

    always_ff @(posedge clk) begin
      if (rst) svld[j+1] <= 1'b0;
      else if (en) svld[j+1] <= svld[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx[j+1]    <= small_m ? (sx[j] <<< SH) : sx[j];
        sy[j+1]    <= small_m ? (sy[j] <<< SH) : sy[j];
        nm[j+1]    <= small_m ? (nm[j] << SH) : nm[j];
        sz[j+1]    <= sz[j];
        sbase[j+1] <= sbase[j];
        szero[j+1] <= szero[j];
        stag[j+1]  <= stag[j];
      end
    end
  end

  // Vectoring CORDIC, one micro-rotation per stage
  for (genvar i = 0; i < CS; i++) begin : g_rot
    localparam int S = NS + i;
    localparam logic [ZW-1:0] STEP = ikl_pkg::atan_step(i);
    logic signed [AW-1:0] xs, ys;
    logic                 ypos;

    assign xs   = sx[S] >>> i;
    assign ys   = sy[S] >>> i;
    assign ypos = !sy[S][AW-1];

    always_ff @(posedge clk) begin
      if (rst) svld[S+1] <= 1'b0;
      else if (en) svld[S+1] <= svld[S];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx[S+1]    <= ypos ? sx[S] + ys : sx[S] - ys;
        sy[S+1]    <= ypos ? sy[S] - xs : sy[S] + xs;
        sz[S+1]    <= ypos ? sz[S] + STEP : sz[S] - STEP;
        sbase[S+1] <= sbase[S];
        szero[S+1] <= szero[S];
        stag[S+1]  <= stag[S];
      end
    end
  end

  // Zero vector gives just the fold offset
  assign angle   = szero[LAST] ? (sbase[LAST] ? ikl_pkg::HALF_TURN : '0) : sz[LAST];
  assign out_vld = svld[LAST];
  assign out_tag = stag[LAST];

endmodule

`default_nettype wire

### design/two_link_inverse_kinematics_unit.sv
// Two-link planar arm inverse kinematics, fully pipelined: each target beat
// runs through front end, sqrt, atan2 and output register to a result beat.
// Throughput one target per cycle while the skid entry is empty; a two-entry
// output (register plus skid) decouples the result side. Synchronous
// active-high reset empties the pipeline and loads both link lengths with 4096.
// Depends on ikl_pkg, ikl_front, ikl_sqrt and ikl_atan2.
`default_nettype none

module two_link_inverse_kinematics_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                target_valid,
  output logic                                     target_ready,
  input  wire ikl_pkg::target_t                    target,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output ikl_pkg::result_t                         result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ikl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [ikl_pkg::LEN_BITS-1:0]        cfg_data
);

  localparam int AW = ikl_pkg::AW;
  localparam int ZW = ikl_pkg::ZW;

  // Link length registers
  logic [ikl_pkg::LEN_BITS-1:0] upper_link_length, lower_link_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= ikl_pkg::LEN_RESET;
      lower_link_length <= ikl_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ikl_pkg::REG_UPPER: upper_link_length <= cfg_data;
        ikl_pkg::REG_LOWER: lower_link_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid entry is free
  logic skid_vld;
  logic en;

  assign en           = !skid_vld;
  assign target_ready = en;

  // Front end
  logic                   f_vld;
  logic [ikl_pkg::SW-1:0] f_a, f_b;
  ikl_pkg::side_t         f_side;

  ikl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (target_valid),
    .target  (target),
    .l1      (upper_link_length),
    .l2      (lower_link_length),
    .out_vld (f_vld),
    .a_opnd  (f_a),
    .b_opnd  (f_b),
    .side    (f_side)
  );

  // Triangle-area square root
  logic                   q_vld;
  logic [ikl_pkg::SW-1:0] q_root;
  ikl_pkg::side_t         q_side;

  ikl_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .a_opnd   (f_a),
    .b_opnd   (f_b),
    .side_in  (f_side),
    .out_vld  (q_vld),
    .root     (q_root),
    .side_out (q_side)
  );

  // Three angles in parallel
  logic signed [AW-1:0] s_ext;
  logic                 g_vld, a_vld, b_vld, g_tag, a_tag, b_tag;
  logic [ZW-1:0]        ang_g, ang_a, ang_b;

  assign s_ext = AW'($signed({1'b0, q_root}));

  ikl_atan2 u_gamma (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (q_vld), .in_tag (q_side.reach),
    .x_in (AW'(q_side.x)), .y_in (AW'(q_side.y)),
    .out_vld (g_vld), .out_tag (g_tag), .angle (ang_g)
  );

  ikl_atan2 u_alpha (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (q_vld), .in_tag (q_side.reach),
    .x_in (AW'(q_side.qa)), .y_in (s_ext),
    .out_vld (a_vld), .out_tag (a_tag), .angle (ang_a)
  );

  ikl_atan2 u_beta (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (q_vld), .in_tag (q_side.reach),
    .x_in (AW'(q_side.nb)), .y_in (s_ext),
    .out_vld (b_vld), .out_tag (b_tag), .angle (ang_b)
  );

  // Joint angles, rounding and reach gating into the output register
  logic             reach_f;
  logic             lvld;
  ikl_pkg::result_t lres, lres_next, skid_res;

  assign reach_f = g_tag & a_tag & b_tag;

  always_comb begin
    lres_next = '0;
    if (reach_f) begin
      lres_next.reachable  = 1'b1;
      lres_next.shoulder_a = ikl_pkg::round_angle(ang_g - ang_a);
      lres_next.elbow_a    = ikl_pkg::round_angle(ikl_pkg::HALF_TURN - ang_b);
      lres_next.shoulder_b = ikl_pkg::round_angle(ang_g + ang_a);
      lres_next.elbow_b    = ikl_pkg::round_angle(ang_b - ikl_pkg::HALF_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) lvld <= 1'b0;
    else if (en) lvld <= g_vld & a_vld & b_vld;
  end

  always_ff @(posedge clk) begin
    if (en) lres <= lres_next;
  end

  // Skid entry catches the output beat when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (result_ready) skid_vld <= 1'b0;
    end else if (lvld && !result_ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld && lvld && !result_ready) skid_res <= lres;
  end

  assign result_valid = skid_vld | lvld;
  assign result       = skid_vld ? skid_res : lres;

endmodule

`default_nettype wire

### design/ikl_checker.sv
// Port-level checker for the inverse kinematics unit, bound to the top level.
// Depends on ikl_pkg and two_link_inverse_kinematics_unit_macros.svh.
`default_nettype none

`include "two_link_inverse_kinematics_unit_macros.svh"

module ikl_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             target_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire ikl_pkg::result_t result
);

  // A stalled result beat holds
  `IKL_ASSERT(a_res_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "result beat changed while stalled")

  // Input back-pressure only while a result is waiting
  `IKL_ASSERT(a_bp_cause, clk, rst, !target_ready |-> result_valid, "target stalled with no result pending")

  // Unreachable targets carry zero angles
  `IKL_ASSERT(a_unreach_zero, clk, rst, result_valid && !result.reachable |-> result.shoulder_a == '0 && result.elbow_a == '0 && result.shoulder_b == '0 && result.elbow_b == '0, "unreachable result with nonzero angle")

  // Nothing comes out straight after reset
  `IKL_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

endmodule

bind two_link_inverse_kinematics_unit ikl_checker u_ikl_checker (
  .clk          (clk),
  .rst          (rst),
  .target_ready (target_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
